// File: src/bfpa_pkg.sv
`timescale 1ns / 1ps
package bfpa_pkg;

	typedef enum logic [3:0] {
		OP_REINIT      = 4'd0,
		OP_ALLOC_BLOCK = 4'd1,
		OP_FREE_BLOCK  = 4'd2,
		OP_ALLOC_FILE  = 4'd3,
		OP_FREE_FILE   = 4'd4,
		OP_PUSH        = 4'd5,
		OP_POP         = 4'd6,
		OP_POP_OLDEST  = 4'd7,
		OP_SET_NEXT    = 4'd8,
		OP_SET_FIRST   = 4'd9
	} op_t;

	typedef struct packed {
		logic [3:0] op;
		logic       item_present;
		logic [3:0] file_index;
		logic [7:0] block_index;
		logic       link_present;
		logic [7:0] link_index;
	} cmd_t;

	typedef struct packed {
		logic       success;
		logic       result_present;
		logic [7:0] result_index;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_DISPATCH,
		ST_ABLK_RD,
		ST_FBLK_RD,
		ST_FF_FIRST,
		ST_FF_WALK_RD,
		ST_FF_WALK,
		ST_PUSH_CHK,
		ST_POP_RD,
		ST_OLD_RD,
		ST_OLD_STEP,
		ST_AFILE_RD,
		ST_DONE
	} state_t;

endpackage

// File: src/bfpa_ram.sv
`timescale 1ns / 1ps
module bfpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: src/block_and_file_pool_allocator.sv
`timescale 1ns / 1ps
// free file and an empty push walk the file's block chain and free each block on it;
// pop oldest walks the ready list hop by hop and unlinks the predecessor of the entry it returns
// throughput: one item at a time, busy is high from start until the result strobe ends
// reset and reinit: a clearing pass of the larger pool count rebuilds the link memories
// with busy high, reinit strobes its result after it; the receiver cannot stall
module block_and_file_pool_allocator #(
	parameter int BLOCK_COUNT = 256,
	parameter int FILE_COUNT  = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  bfpa_pkg::cmd_t cmd,
	output logic           busy,
	output logic           done,
	output bfpa_pkg::rsp_t rsp
);
	import bfpa_pkg::*;

	localparam int BW = $clog2(BLOCK_COUNT);
	localparam int FW = $clog2(FILE_COUNT);
	localparam int XW = (BW > FW) ? BW : FW;
	localparam int NCLR = (BLOCK_COUNT > FILE_COUNT) ? BLOCK_COUNT : FILE_COUNT;
	localparam int CW = $clog2(NCLR + 1);

	// block link memory: {valid, index}
	logic          b_we;
	logic [BW-1:0] b_waddr, b_raddr;
	logic [BW:0]   b_wdata, b_rdata;
	// file memory: {link valid, link index, first valid, first index}
	logic          f_we;
	logic [FW-1:0] f_waddr, f_raddr;
	logic [FW+BW+1:0] f_wdata, f_rdata;

	bfpa_ram #(.WIDTH(BW + 1), .DEPTH(BLOCK_COUNT)) u_blk (
		.clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
		.raddr(b_raddr), .rdata(b_rdata)
	);
	bfpa_ram #(.WIDTH(FW + BW + 2), .DEPTH(FILE_COUNT)) u_file (
		.clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
		.raddr(f_raddr), .rdata(f_rdata)
	);

	state_t state_q, state_d;
	cmd_t   cmd_q, cmd_d;
	rsp_t   rsp_q, rsp_d;
	logic [BW:0] fbh_q, fbh_d;
	logic [FW:0] ffh_q, ffh_d, rfh_q, rfh_d;
	logic [XW:0] cur_q, cur_d;
	logic [FW:0] prev_q, prev_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [FW+BW+1:0] frec_q, frec_d;
	logic reinit_q;

	logic          f_lv, f_fv;
	logic [FW-1:0] f_li;
	logic [BW:0]   f_first;
	logic          file_ok, block_ok;
	logic [BW:0]   link_w;
	logic [FW-1:0] arg_f;
	logic [BW-1:0] arg_b;

	assign f_lv    = f_rdata[FW+BW+1];
	assign f_li    = f_rdata[FW+BW:BW+1];
	assign f_first = f_rdata[BW:0];
	assign f_fv    = f_rdata[BW];
	assign arg_f   = FW'(cmd_q.file_index);
	assign arg_b   = BW'(cmd_q.block_index);
	assign file_ok  = cmd_q.item_present && (32'(cmd_q.file_index) < FILE_COUNT);
	assign block_ok = cmd_q.item_present && (32'(cmd_q.block_index) < BLOCK_COUNT);
	assign link_w = (cmd_q.link_present && (32'(cmd_q.link_index) < BLOCK_COUNT)) ?
		{1'b1, BW'(cmd_q.link_index)} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q   <= '0;
			fbh_q   <= {1'b1, BW'(0)};
			ffh_q   <= {1'b1, FW'(0)};
			rfh_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			fbh_q   <= fbh_d;
			ffh_q   <= ffh_d;
			rfh_q   <= rfh_d;
		end
	end

	always_ff @(posedge clk) begin
		cmd_q  <= cmd_d;
		rsp_q  <= rsp_d;
		cur_q  <= cur_d;
		prev_q <= prev_d;
		frec_q <= frec_d;
	end

	always_comb begin
		state_d = state_q;
		cmd_d = cmd_q; rsp_d = rsp_q;
		fbh_d = fbh_q; ffh_d = ffh_q; rfh_d = rfh_q;
		cur_d = cur_q; prev_d = prev_q; cnt_d = cnt_q; frec_d = frec_q;
		b_we = 1'b0; b_waddr = '0; b_wdata = '0; b_raddr = '0;
		f_we = 1'b0; f_waddr = '0; f_wdata = '0; f_raddr = '0;
		done = 1'b0;
		busy = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd_d = cmd;
					rsp_d = '0;
					state_d = ST_DISPATCH;
				end
			end
			ST_CLEAR: begin
				if (32'(cnt_q) < BLOCK_COUNT) begin
					b_we = 1'b1;
					b_waddr = BW'(cnt_q);
					b_wdata = (32'(cnt_q) + 1 < BLOCK_COUNT) ?
						{1'b1, BW'(cnt_q + 1'b1)} : '0;
				end
				if (32'(cnt_q) < FILE_COUNT) begin
					f_we = 1'b1;
					f_waddr = FW'(cnt_q);
					f_wdata = (32'(cnt_q) + 1 < FILE_COUNT) ?
						{1'b1, FW'(cnt_q + 1'b1), (BW + 1)'(0)} : '0;
				end
				cnt_d = cnt_q + 1'b1;
				if (32'(cnt_q) == NCLR - 1) begin
					cnt_d = '0;
					state_d = reinit_q ? ST_DONE : ST_IDLE;
				end
			end
			ST_DISPATCH: begin
				state_d = ST_DONE;
				unique case (cmd_q.op)
					OP_REINIT: begin
						rsp_d.success = 1'b1;
						fbh_d = {1'b1, BW'(0)};
						ffh_d = {1'b1, FW'(0)};
						rfh_d = '0;
						cnt_d = '0;
						done = 1'b0;
						state_d = ST_CLEAR;
					end
					OP_ALLOC_BLOCK: begin
						b_raddr = fbh_q[BW-1:0];
						if (fbh_q[BW]) state_d = ST_ABLK_RD;
					end
					OP_FREE_BLOCK: begin
						b_raddr = arg_b;
						if (block_ok) state_d = ST_FBLK_RD;
					end
					OP_ALLOC_FILE: begin
						f_raddr = ffh_q[FW-1:0];
						if (ffh_q[FW]) state_d = ST_AFILE_RD;
					end
					OP_FREE_FILE: begin
						f_raddr = arg_f;
						if (file_ok) begin
							rsp_d.success = 1'b1;
							state_d = ST_FF_FIRST;
						end
					end
					OP_PUSH: begin
						f_raddr = arg_f;
						if (file_ok) state_d = ST_PUSH_CHK;
					end
					OP_POP: begin
						f_raddr = rfh_q[FW-1:0];
						if (rfh_q[FW]) state_d = ST_POP_RD;
					end
					OP_POP_OLDEST: begin
						f_raddr = rfh_q[FW-1:0];
						cur_d = (XW + 1)'(rfh_q);
						prev_d = '0;
						cnt_d = '0;
						if (rfh_q[FW]) state_d = ST_OLD_RD;
					end
					OP_SET_NEXT: begin
						f_raddr = arg_f;
						if (block_ok) begin
							b_we = 1'b1; b_waddr = arg_b; b_wdata = link_w;
							rsp_d.success = 1'b1;
						end
					end
					OP_SET_FIRST: begin
						f_raddr = arg_f;
						if (file_ok) begin
							rsp_d.success = 1'b1;
							state_d = ST_PUSH_CHK;
						end
					end
					default: ;
				endcase
			end
			ST_ABLK_RD: begin
				rsp_d = '{1'b1, 1'b1, 8'(fbh_q[BW-1:0])};
				fbh_d = b_rdata;
				b_we = 1'b1; b_waddr = fbh_q[BW-1:0]; b_wdata = '0;
				state_d = ST_DONE;
			end
			ST_FBLK_RD: begin
				rsp_d.success = 1'b1;
				rsp_d.result_present = b_rdata[BW];
				rsp_d.result_index = b_rdata[BW] ? 8'(b_rdata[BW-1:0]) : 8'd0;
				b_we = 1'b1; b_waddr = arg_b; b_wdata = fbh_q;
				fbh_d = {1'b1, arg_b};
				state_d = ST_DONE;
			end
			ST_AFILE_RD: begin
				rsp_d = '{1'b1, 1'b1, 8'(ffh_q[FW-1:0])};
				ffh_d = {f_lv, f_li};
				f_we = 1'b1; f_waddr = ffh_q[FW-1:0]; f_wdata = '0;
				state_d = ST_DONE;
			end
			ST_PUSH_CHK: begin
				if (cmd_q.op == OP_SET_FIRST) begin
					f_we = 1'b1; f_waddr = arg_f;
					f_wdata = {f_lv, f_li, link_w};
					state_d = ST_DONE;
				end else if (f_fv) begin
					rsp_d.success = 1'b1;
					f_we = 1'b1; f_waddr = arg_f;
					f_wdata = {rfh_q, f_first};
					rfh_d = {1'b1, arg_f};
					state_d = ST_DONE;
				end else begin
					frec_d = f_rdata;
					cur_d = (XW + 1)'(f_first);
					cnt_d = '0;
					state_d = ST_FF_WALK_RD;
				end
			end
			ST_FF_FIRST: begin
				frec_d = f_rdata;
				cur_d = (XW + 1)'(f_first);
				cnt_d = '0;
				state_d = ST_FF_WALK_RD;
			end
			ST_FF_WALK_RD: begin
				b_raddr = cur_q[BW-1:0];
				if (cur_q[BW] && (32'(cnt_q) < BLOCK_COUNT)) begin
					state_d = ST_FF_WALK;
				end else begin
					f_we = 1'b1; f_waddr = arg_f;
					f_wdata = {ffh_q, frec_q[BW:0]};
					ffh_d = {1'b1, arg_f};
					state_d = ST_DONE;
				end
			end
			ST_FF_WALK: begin
				b_we = 1'b1; b_waddr = cur_q[BW-1:0]; b_wdata = fbh_q;
				fbh_d = cur_q[BW:0];
				cur_d = (XW + 1)'(b_rdata);
				cnt_d = cnt_q + 1'b1;
				state_d = ST_FF_WALK_RD;
			end
			ST_OLD_RD: begin
				f_raddr = cur_q[FW-1:0];
				state_d = ST_OLD_STEP;
			end
			ST_OLD_STEP: begin
				if (f_lv && (32'(cnt_q) + 1 < FILE_COUNT)) begin
					prev_d = {1'b1, cur_q[FW-1:0]};
					cur_d = (XW + 1)'({f_lv, f_li});
					cnt_d = cnt_q + 1'b1;
					f_raddr = f_li;
					state_d = ST_OLD_RD;
				end else begin
					if (prev_q[FW]) begin
						f_raddr = prev_q[FW-1:0];
						state_d = ST_POP_RD;
					end else begin
						rfh_d = '0;
						state_d = ST_DONE;
					end
					rsp_d = '{1'b1, 1'b1, 8'(cur_q[FW-1:0])};
				end
			end
			ST_POP_RD: begin
				if (cmd_q.op == OP_POP) begin
					rsp_d = '{1'b1, 1'b1, 8'(rfh_q[FW-1:0])};
					rfh_d = {f_lv, f_li};
				end else begin
					f_we = 1'b1; f_waddr = prev_q[FW-1:0];
					f_wdata = {(FW + 1)'(0), f_first};
				end
				state_d = ST_DONE;
			end
			ST_DONE: begin
				done = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
		if (state_q == ST_DISPATCH && cmd_q.op == OP_REINIT) begin
			done = 1'b0;
		end
	end

	// reinit answers after its clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reinit_q <= 1'b0;
		end else if (state_q == ST_DISPATCH) begin
			reinit_q <= (cmd_q.op == OP_REINIT);
		end else if (state_q == ST_CLEAR && state_d != ST_CLEAR) begin
			reinit_q <= 1'b0;
		end
	end

	assign rsp = rsp_q;
endmodule

// File: src/bfpa_checker.sv
`timescale 1ns / 1ps
module bfpa_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           done,
	input bfpa_pkg::rsp_t rsp
);
	import bfpa_pkg::*;

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("item not taken");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done longer than one cycle");
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("done while idle");
	a_null_idx: assert property (@(posedge clk) disable iff (!arst_n)
		done && !rsp.result_present |-> rsp.result_index == 8'd0)
		else $error("index without present");
endmodule

bind block_and_file_pool_allocator bfpa_checker u_bfpa_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done), .rsp(rsp)
);

// File: test/block_and_file_pool_allocator_test.sv
`timescale 1ns / 1ps
module block_and_file_pool_allocator_test;
	import bfpa_pkg::*;

	localparam int NBLK = 256;
	localparam int NFILE = 16;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	cmd_t cmd = '0;
	logic busy;
	logic done;
	rsp_t rsp;

	block_and_file_pool_allocator #(.BLOCK_COUNT(NBLK), .FILE_COUNT(NFILE)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .cmd(cmd),
		.busy(busy), .done(done), .rsp(rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// allocator state: link is {valid, index}
	logic [8:0] blk_link [NBLK];
	logic [4:0] file_link [NFILE];
	logic [8:0] file_first [NFILE];
	logic [8:0] blk_head;
	logic [4:0] file_head;
	logic [4:0] ready_head;

	rsp_t expected_rsp [$];
	int errors = 0;
	int items_sent = 0;
	int results_seen = 0;
	bit idle_on = 1'b1;
	int op_hits [16];

	task automatic pool_reset();
		for (int i = 0; i < NBLK; i++)
			blk_link[i] = (i + 1 < NBLK) ? {1'b1, 8'(i + 1)} : 9'd0;
		for (int i = 0; i < NFILE; i++) begin
			file_link[i] = (i + 1 < NFILE) ? {1'b1, 4'(i + 1)} : 5'd0;
			file_first[i] = 9'd0;
		end
		blk_head = 9'h100;
		file_head = 5'h10;
		ready_head = 5'd0;
	endtask

	function automatic logic [8:0] release_blk(logic [7:0] b);
		logic [8:0] s;
		s = blk_link[b];
		blk_link[b] = blk_head;
		blk_head = {1'b1, b};
		return s;
	endfunction

	task automatic release_file(logic [3:0] f);
		logic [8:0] cur;
		int steps;
		cur = file_first[f];
		steps = 0;
		while (cur[8] && steps < NBLK) begin
			cur = release_blk(cur[7:0]);
			steps++;
		end
		file_link[f] = file_head;
		file_head = {1'b1, f};
	endtask

	task automatic predict_pool(cmd_t c, output rsp_t r);
		logic ok;
		logic [8:0] lnk;
		logic [8:0] ret;
		logic [4:0] cur, prev, nx;
		int hops;
		ok = 1'b0;
		ret = 9'd0;
		lnk = c.link_present ? {1'b1, c.link_index} : 9'd0;
		case (c.op)
			OP_REINIT: begin
				pool_reset();
				ok = 1'b1;
			end
			OP_ALLOC_BLOCK: begin
				ret = blk_head;
				if (ret[8]) begin
					blk_head = blk_link[ret[7:0]];
					blk_link[ret[7:0]] = 9'd0;
					ok = 1'b1;
				end
			end
			OP_FREE_BLOCK: if (c.item_present) begin
				ret = release_blk(c.block_index);
				ok = 1'b1;
			end
			OP_ALLOC_FILE: begin
				ret = {file_head[4], 4'd0, file_head[3:0]};
				if (file_head[4]) begin
					file_head = file_link[ret[3:0]];
					file_link[ret[3:0]] = 5'd0;
					file_first[ret[3:0]] = 9'd0;
					ok = 1'b1;
				end
			end
			OP_FREE_FILE: if (c.item_present) begin
				release_file(c.file_index);
				ok = 1'b1;
			end
			OP_PUSH: if (c.item_present) begin
				if (file_first[c.file_index][8]) begin
					file_link[c.file_index] = ready_head;
					ready_head = {1'b1, c.file_index};
					ok = 1'b1;
				end else begin
					release_file(c.file_index);
				end
			end
			OP_POP: begin
				ret = {ready_head[4], 4'd0, ready_head[3:0]};
				if (ready_head[4]) begin
					ready_head = file_link[ready_head[3:0]];
					ok = 1'b1;
				end
			end
			OP_POP_OLDEST: begin
				cur = ready_head;
				prev = 5'd0;
				hops = 0;
				while (cur[4]) begin
					nx = file_link[cur[3:0]];
					if (!nx[4] || hops + 1 >= NFILE) break;
					prev = cur;
					cur = nx;
					hops++;
				end
				if (prev[4]) file_link[prev[3:0]] = 5'd0;
				else ready_head = 5'd0;
				ret = {cur[4], 4'd0, cur[3:0]};
				ok = cur[4];
			end
			OP_SET_NEXT: if (c.item_present) begin
				blk_link[c.block_index] = lnk;
				ok = 1'b1;
			end
			OP_SET_FIRST: if (c.item_present) begin
				file_first[c.file_index] = lnk;
				ok = 1'b1;
			end
			default: ;
		endcase
		r.success = ok;
		r.result_present = ret[8];
		r.result_index = ret[8] ? ret[7:0] : 8'd0;
	endtask

	task automatic pause_random();
		int n;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			n = $urandom_range(1, 10);
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send_item(cmd_t c);
		rsp_t r;
		pause_random();
		while (busy) @(posedge clk);
		predict_pool(c, r);
		expected_rsp.push_back(r);
		op_hits[c.op]++;
		items_sent++;
		start <= 1'b1;
		cmd <= c;
		@(posedge clk);
		start <= 1'b0;
		cmd <= '0;
		@(posedge clk);
	endtask

	function automatic cmd_t mk(int op, int ip, int fi, int bi, int lp, int li);
		cmd_t c;
		c.op = 4'(op);
		c.item_present = 1'(ip);
		c.file_index = 4'(fi);
		c.block_index = 8'(bi);
		c.link_present = 1'(lp);
		c.link_index = 8'(li);
		return c;
	endfunction

	function automatic cmd_t rand_cmd(logic [3:0] op);
		cmd_t c;
		c = cmd_t'($urandom);
		c.op = op;
		c.item_present = ($urandom_range(0, 9) != 0);
		return c;
	endfunction

	always @(posedge clk) begin
		if (done) begin
			results_seen++;
			if (expected_rsp.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %h", rsp);
			end else begin
				rsp_t e;
				e = expected_rsp.pop_front();
				if (rsp.success !== e.success || rsp.result_present !== e.result_present
						|| rsp.result_index !== e.result_index) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: expected %b/%b/%h got %b/%b/%h",
							e.success, e.result_present, e.result_index,
							rsp.success, rsp.result_present, rsp.result_index);
				end
			end
		end
	end

	task automatic test_directed();
		send_item(mk(OP_ALLOC_BLOCK, 1, 0, 0, 0, 0));
		send_item(mk(OP_ALLOC_FILE, 1, 0, 0, 0, 0));
		send_item(mk(OP_SET_FIRST, 1, 0, 0, 1, 8'd0));
		send_item(mk(OP_SET_NEXT, 1, 0, 8'd0, 1, 8'd255));
		send_item(mk(OP_SET_NEXT, 1, 0, 8'd255, 0, 8'd255));
		send_item(mk(OP_PUSH, 1, 4'd0, 0, 0, 0));
		send_item(mk(OP_PUSH, 1, 4'd15, 0, 0, 0));
		send_item(mk(OP_POP_OLDEST, 0, 0, 0, 0, 0));
		send_item(mk(OP_POP, 0, 0, 0, 0, 0));
		send_item(mk(OP_POP, 0, 0, 0, 0, 0));
		send_item(mk(OP_FREE_FILE, 1, 4'd0, 0, 0, 0));
		send_item(mk(OP_FREE_BLOCK, 1, 0, 8'd255, 0, 0));
		send_item(mk(OP_FREE_BLOCK, 0, 4'hf, 8'd7, 1, 8'hff));
		send_item(mk(OP_FREE_FILE, 0, 4'd3, 0, 0, 0));
		send_item(mk(OP_SET_FIRST, 0, 4'd3, 0, 1, 8'd9));
		// cyclic chain and cyclic ready list
		send_item(mk(OP_SET_NEXT, 1, 0, 8'd5, 1, 8'd5));
		send_item(mk(OP_SET_FIRST, 1, 4'd2, 0, 1, 8'd5));
		send_item(mk(OP_FREE_FILE, 1, 4'd2, 0, 0, 0));
		send_item(mk(OP_PUSH, 1, 4'd4, 0, 0, 0));
		send_item(mk(OP_SET_FIRST, 1, 4'd4, 0, 1, 8'd1));
		send_item(mk(OP_PUSH, 1, 4'd4, 0, 0, 0));
		send_item(mk(OP_PUSH, 1, 4'd4, 0, 0, 0));
		send_item(mk(OP_POP_OLDEST, 1, 0, 0, 0, 0));
		send_item(mk(4'd10, 1, 4'hf, 8'hff, 1, 8'hff));
		send_item(mk(4'd15, 1, 4'hf, 8'hff, 1, 8'hff));
		send_item(mk(OP_REINIT, 0, 0, 0, 0, 0));
	endtask

	// weighted random ops with random operands, undefined op codes mixed in
	task automatic test_random(int n);
		cmd_t c;
		int k;
		for (int i = 0; i < n; i++) begin
			if (i > n - 150) idle_on = 1'b0;
			k = $urandom_range(0, 99);
			if (k < 20) c = rand_cmd(OP_ALLOC_BLOCK);
			else if (k < 32) c = rand_cmd(OP_ALLOC_FILE);
			else if (k < 42) begin
				c = rand_cmd(OP_SET_NEXT);
				c.link_index = 8'($urandom_range(0, 15));
			end else if (k < 52) begin
				c = rand_cmd(OP_SET_FIRST);
				c.link_index = 8'($urandom_range(0, 15));
			end else if (k < 62) c = rand_cmd(OP_PUSH);
			else if (k < 70) c = rand_cmd(OP_POP);
			else if (k < 77) c = rand_cmd(OP_POP_OLDEST);
			else if (k < 84) c = rand_cmd(OP_FREE_BLOCK);
			else if (k < 91) c = rand_cmd(OP_FREE_FILE);
			else if (k < 93) c = rand_cmd(OP_REINIT);
			else c = rand_cmd(4'($urandom_range(0, 15)));
			send_item(c);
		end
	endtask

	initial begin
		pool_reset();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(1930);
		while (expected_rsp.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("sent %0d items, checked %0d results", items_sent, results_seen);
		$display("ops: alloc blk %0d, free file %0d, pop oldest %0d, reinit %0d",
			op_hits[OP_ALLOC_BLOCK], op_hits[OP_FREE_FILE], op_hits[OP_POP_OLDEST],
			op_hits[OP_REINIT]);
		if (errors == 0 && expected_rsp.size() == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end

	initial begin
		#100ms;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// File: files.f
src/bfpa_pkg.sv
src/bfpa_ram.sv
src/block_and_file_pool_allocator.sv
src/bfpa_checker.sv
test/block_and_file_pool_allocator_test.sv
